@@ design/lbpm_pkg.sv @@
// Package for the light bar pair matcher: stored entry layout, field widths
// and configuration register indexes. Used by the top level; no dependencies.
`default_nettype none
package lbpm_pkg;

    // Field widths fixed by the stream format.
    localparam int COORD_W = 16;
    localparam int ANGLE_IN_W = 12;
    localparam int ANGLE_W = 13;
    localparam int INDEX_W = 6;
    localparam int AREA_W = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    // Ninety degrees in Q8.4.
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 13'sd1440;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AREA_RATIO_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ASPECT_LOW = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ASPECT_HIGH = 3'd4;

    // One kept rectangle as held in the rectangle memory.
    typedef struct packed {
        logic [COORD_W-1:0]        pos_x;
        logic [COORD_W-1:0]        pos_y;
        logic [COORD_W-1:0]        size_w;
        logic [COORD_W-1:0]        size_h;
        logic [AREA_W-1:0]         area;
        logic signed [ANGLE_W-1:0] angle;
        logic [INDEX_W-1:0]        index;
    } rect_entry_t;

    localparam int ENTRY_W = $bits(rect_entry_t);

    // One emitted pair as held in the pair memory.
    typedef struct packed {
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] second_index;
    } pair_entry_t;

    localparam int PAIR_W = $bits(pair_entry_t);

endpackage
`default_nettype wire

@@ design/light_bar_pair_matcher.sv @@
// Light bar pair matcher top level: input filter, sorted insertion into the rectangle
// memory, pair scan and result emission. Uses lbpm_pkg and lbpm_ram.
// A beat is taken and then checked; a kept one is inserted by moving each kept entry
// with a larger centre y up one place, and s_tready is high only while idle. The scan
// reads each first entry and tests its partners until the run ends; each result beat
// is held until m_tready takes it. Sync reset empties the set.
`default_nettype none
module light_bar_pair_matcher #(
    parameter int MAX_RECTS = 64,
    parameter int MAX_PAIRS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata, low bit up: center_x, center_y, rect_width, rect_height,
    // rect_angle, zero fill
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata, low bit up: first_index, second_index, overflowed, zero fill
    output logic      [15:0] m_tdata,
    output logic             m_tuser,  // pair_valid
    output logic             m_tlast,  // last_result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int KW = $clog2(MAX_RECTS + 1);
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int PW = $clog2(MAX_PAIRS + 1);
    localparam int PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_CHECK   = 12'b0000_0000_0010,
        ST_INS_RD  = 12'b0000_0000_0100,
        ST_INS_CMP = 12'b0000_0000_1000,
        ST_SC_RDI  = 12'b0000_0001_0000,
        ST_SC_WI   = 12'b0000_0010_0000,
        ST_SC_RDJ  = 12'b0000_0100_0000,
        ST_SC_WJ   = 12'b0000_1000_0000,
        ST_SC_DEC  = 12'b0001_0000_0000,
        ST_EM_RD   = 12'b0010_0000_0000,
        ST_EM_WAIT = 12'b0100_0000_0000,
        ST_EM_OUT  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [11:0] angle_limit_reg;
    logic [15:0] vertical_limit_reg, area_ratio_limit_reg, aspect_low_reg, aspect_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_limit_reg      <= 12'd160;
            vertical_limit_reg   <= 16'd4096;
            area_ratio_limit_reg <= 16'd512;
            aspect_low_reg       <= 16'd256;
            aspect_high_reg      <= 16'd2560;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lbpm_pkg::REG_ANGLE_LIMIT:      angle_limit_reg <= cfg_wdata[11:0];
                lbpm_pkg::REG_VERTICAL_LIMIT:   vertical_limit_reg <= cfg_wdata;
                lbpm_pkg::REG_AREA_RATIO_LIMIT: area_ratio_limit_reg <= cfg_wdata;
                lbpm_pkg::REG_ASPECT_LOW:       aspect_low_reg <= cfg_wdata;
                lbpm_pkg::REG_ASPECT_HIGH:      aspect_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control counters.
    logic [KW-1:0] kept_reg, arrival_reg, ins_pos_reg, i_reg, j_reg;
    logic [PW-1:0] pair_cnt_reg, emit_reg;
    logic          overflow_reg, full_reg;

    // Captured input beat.
    logic [15:0]       in_x_reg, in_y_reg, in_w_reg, in_h_reg;
    logic signed [11:0] in_angle_reg;
    logic              in_last_reg, in_drop_reg;
    logic [5:0]        in_index_reg;
    lbpm_pkg::rect_entry_t new_entry_reg;

    // Scan operands and staged products.
    lbpm_pkg::rect_entry_t e1_reg, e2_reg;
    logic [18:0] reach_reg;
    logic [31:0] vh_reg;
    logic [15:0] dx_reg, dy_reg;
    logic [13:0] da_reg;
    logic [31:0] amax_reg;
    logic [47:0] gap_rhs_reg, area_rhs_reg;

    // Output register.
    logic [5:0] out_first_reg, out_second_reg;
    logic       out_pair_reg, out_last_reg, out_valid_reg;

    // Memory ports.
    logic                  rect_we;
    logic [AW-1:0]         rect_waddr, rect_raddr;
    lbpm_pkg::rect_entry_t rect_wdata, rect_rdata;
    logic                  pair_we;
    logic [PAW-1:0]        pair_raddr;
    lbpm_pkg::pair_entry_t pair_wdata, pair_rdata;

    lbpm_ram #(.WIDTH(lbpm_pkg::ENTRY_W), .DEPTH(MAX_RECTS)) u_rect_ram (
        .aclk    (aclk),
        .wr_en   (rect_we),
        .wr_addr (rect_waddr),
        .wr_data (rect_wdata),
        .rd_addr (rect_raddr),
        .rd_data (rect_rdata)
    );

    lbpm_ram #(.WIDTH(lbpm_pkg::PAIR_W), .DEPTH(MAX_PAIRS)) u_pair_ram (
        .aclk    (aclk),
        .wr_en   (pair_we),
        .wr_addr (pair_cnt_reg[PAW-1:0]),
        .wr_data (pair_wdata),
        .rd_addr (pair_raddr),
        .rd_data (pair_rdata)
    );

    // Filter of the captured rectangle.
    logic [15:0] side_lo, side_hi;
    logic [31:0] hi_scaled, low_bound, high_bound;
    logic        keep;
    logic signed [12:0] angle_adj;

    always_comb begin
        side_lo    = (in_w_reg < in_h_reg) ? in_w_reg : in_h_reg;
        side_hi    = (in_w_reg < in_h_reg) ? in_h_reg : in_w_reg;
        hi_scaled  = {8'd0, side_hi, 8'd0};
        low_bound  = aspect_low_reg * side_lo;
        high_bound = aspect_high_reg * side_lo;
        keep = !in_drop_reg && (in_w_reg != '0) && (in_h_reg != '0)
            && (hi_scaled >= low_bound) && (hi_scaled <= high_bound);
        angle_adj = 13'(in_angle_reg);
        if (in_w_reg < in_h_reg) begin
            angle_adj = angle_adj + lbpm_pkg::QUARTER_TURN;
        end
    end

    // Pair decision from staged values.
    logic brk_x, brk_y, is_match;

    always_comb begin
        brk_x    = 19'(dx_reg) > reach_reg;
        brk_y    = 48'({dy_reg, 16'd0}) > gap_rhs_reg;
        is_match = (da_reg <= 14'(angle_limit_reg))
            && (48'({amax_reg, 8'd0}) <= area_rhs_reg);
    end

    // Partner operand arithmetic on the freshly read entry.
    logic [15:0] dx_c;
    logic signed [13:0] da_s;
    logic [31:0] amax_c, amin_c;

    always_comb begin
        dx_c = (rect_rdata.pos_x > e1_reg.pos_x) ? rect_rdata.pos_x - e1_reg.pos_x
                                                 : e1_reg.pos_x - rect_rdata.pos_x;
        da_s = 14'(e1_reg.angle) - 14'(rect_rdata.angle);
        amax_c = (e1_reg.area > rect_rdata.area) ? e1_reg.area : rect_rdata.area;
        amin_c = (e1_reg.area > rect_rdata.area) ? rect_rdata.area : e1_reg.area;
    end

    // Memory port control.
    always_comb begin
        rect_we    = 1'b0;
        rect_waddr = ins_pos_reg[AW-1:0];
        rect_wdata = new_entry_reg;
        rect_raddr = '0;
        pair_we    = 1'b0;
        pair_wdata = '{first_index: e1_reg.index, second_index: e2_reg.index};
        pair_raddr = emit_reg[PAW-1:0];
        unique case (state_reg)
            ST_INS_RD: begin
                if (ins_pos_reg == '0) begin
                    rect_we = 1'b1;
                end else begin
                    rect_raddr = AW'(ins_pos_reg - 1'b1);
                end
            end
            ST_INS_CMP: begin
                rect_we = 1'b1;
                if (rect_rdata.pos_y > new_entry_reg.pos_y) begin
                    rect_wdata = rect_rdata;
                end
            end
            ST_SC_RDI: rect_raddr = i_reg[AW-1:0];
            ST_SC_RDJ: rect_raddr = j_reg[AW-1:0];
            ST_SC_DEC: pair_we = is_match && !brk_x && !brk_y
                && (pair_cnt_reg < PW'(MAX_PAIRS));
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK:   state_next = keep ? ST_INS_RD : (in_last_reg ? ST_SC_RDI : ST_IDLE);
            ST_INS_RD: begin
                if (ins_pos_reg == '0) state_next = in_last_reg ? ST_SC_RDI : ST_IDLE;
                else state_next = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (rect_rdata.pos_y > new_entry_reg.pos_y) state_next = ST_INS_RD;
                else state_next = in_last_reg ? ST_SC_RDI : ST_IDLE;
            end
            ST_SC_RDI:  state_next = (full_reg || i_reg >= kept_reg) ? ST_EM_RD : ST_SC_WI;
            ST_SC_WI:   state_next = ST_SC_RDJ;
            ST_SC_RDJ:  state_next = (j_reg >= kept_reg) ? ST_SC_RDI : ST_SC_WJ;
            ST_SC_WJ:   state_next = ST_SC_DEC;
            ST_SC_DEC: begin
                if (brk_x || brk_y) state_next = ST_SC_RDI;
                else if (is_match && pair_cnt_reg >= PW'(MAX_PAIRS)) state_next = ST_SC_RDI;
                else state_next = ST_SC_RDJ;
            end
            ST_EM_RD:   state_next = (pair_cnt_reg == '0) ? ST_EM_OUT : ST_EM_WAIT;
            ST_EM_WAIT: state_next = ST_EM_OUT;
            ST_EM_OUT: begin
                if (m_tready) state_next = out_last_reg ? ST_IDLE : ST_EM_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kept_reg      <= '0;
            arrival_reg   <= '0;
            overflow_reg  <= 1'b0;
            full_reg      <= 1'b0;
            pair_cnt_reg  <= '0;
            emit_reg      <= '0;
            ins_pos_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (arrival_reg >= KW'(MAX_RECTS)) overflow_reg <= 1'b1;
                        else arrival_reg <= arrival_reg + 1'b1;
                    end
                    full_reg     <= 1'b0;
                    pair_cnt_reg <= '0;
                    emit_reg     <= '0;
                    i_reg        <= '0;
                end
                ST_CHECK:  ins_pos_reg <= kept_reg;
                ST_INS_RD: if (ins_pos_reg == '0) kept_reg <= kept_reg + 1'b1;
                ST_INS_CMP: begin
                    if (rect_rdata.pos_y > new_entry_reg.pos_y) begin
                        ins_pos_reg <= ins_pos_reg - 1'b1;
                    end else begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                end
                ST_SC_WI: j_reg <= i_reg + 1'b1;
                ST_SC_RDJ: if (j_reg >= kept_reg) i_reg <= i_reg + 1'b1;
                ST_SC_DEC: begin
                    if (brk_x || brk_y) begin
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        if (is_match) begin
                            if (pair_cnt_reg >= PW'(MAX_PAIRS)) begin
                                overflow_reg <= 1'b1;
                                full_reg     <= 1'b1;
                            end else begin
                                pair_cnt_reg <= pair_cnt_reg + 1'b1;
                            end
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_EM_RD: if (pair_cnt_reg == '0) out_valid_reg <= 1'b1;
                ST_EM_WAIT: out_valid_reg <= 1'b1;
                ST_EM_OUT: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        emit_reg      <= emit_reg + 1'b1;
                        if (out_last_reg) begin
                            kept_reg     <= '0;
                            arrival_reg  <= '0;
                            overflow_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            in_x_reg     <= s_tdata[15:0];
            in_y_reg     <= s_tdata[31:16];
            in_w_reg     <= s_tdata[47:32];
            in_h_reg     <= s_tdata[63:48];
            in_angle_reg <= s_tdata[75:64];
            in_last_reg  <= s_tlast;
            in_drop_reg  <= arrival_reg >= KW'(MAX_RECTS);
            in_index_reg <= 6'(arrival_reg);
        end
        if (state_reg == ST_CHECK) begin
            new_entry_reg <= '{pos_x: in_x_reg, pos_y: in_y_reg, size_w: in_w_reg,
                size_h: in_h_reg, area: in_w_reg * in_h_reg, angle: angle_adj,
                index: in_index_reg};
        end
        if (state_reg == ST_SC_WI) begin
            e1_reg    <= rect_rdata;
            vh_reg    <= vertical_limit_reg * rect_rdata.size_h;
            reach_reg <= 19'(((rect_rdata.size_w > rect_rdata.size_h) ? rect_rdata.size_w
                : rect_rdata.size_h)) * 19'd5;
        end
        if (state_reg == ST_SC_WJ) begin
            e2_reg       <= rect_rdata;
            dx_reg       <= dx_c;
            dy_reg       <= rect_rdata.pos_y - e1_reg.pos_y;
            da_reg       <= (da_s < 0) ? 14'(-da_s) : 14'(da_s);
            amax_reg     <= amax_c;
            gap_rhs_reg  <= vh_reg * rect_rdata.pos_y;
            area_rhs_reg <= area_ratio_limit_reg * amin_c;
        end
        if (state_reg == ST_EM_RD && pair_cnt_reg == '0) begin
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_pair_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
        end
        if (state_reg == ST_EM_WAIT) begin
            out_first_reg  <= pair_rdata.first_index;
            out_second_reg <= pair_rdata.second_index;
            out_pair_reg   <= 1'b1;
            out_last_reg   <= (emit_reg + 1'b1) == pair_cnt_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, overflow_reg, out_second_reg, out_first_reg};
    assign m_tuser  = out_pair_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

@@ design/lbpm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module lbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

@@ design/lbpm_checker.sv @@
// Port-level checker for the light bar pair matcher, bound to the top level.
// No dependencies beyond the top level's ports.
`default_nettype none
module lbpm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Input is never taken while a result is being shown.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready while result pending");

    // A beat without a pair is the only and last result, with zero indices.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[11:0] == 12'd0)
        else $error("empty result is not a lone final beat");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid just after reset");

endmodule

bind light_bar_pair_matcher lbpm_checker u_lbpm_checker (.*);
`default_nettype wire
